### design/glzw_pkg.sv
package glzw_pkg;

  localparam int MAX_CODE_BITS   = 12;
  localparam int TABLE_ENTRIES   = 4096;
  localparam int PALETTE_ENTRIES = 256;

  localparam int TAB_AW  = $clog2(TABLE_ENTRIES);
  localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);
  localparam int NFC_W   = MAX_CODE_BITS + 1;
  localparam int DEPTH_W = TAB_AW + 1;
  localparam int CW_W    = 4;
  localparam int BUF_BITS = 24;
  localparam int CNT_W   = 5;

  localparam logic [3:0] MCS_RESET = 4'd8;
  localparam logic [3:0] MCS_LOW   = 4'd2;
  localparam logic [3:0] MCS_HIGH  = 4'd8;

  typedef enum logic [1:0] {
    MODE_PALETTE = 2'd0,
    MODE_PUSH    = 2'd1,
    MODE_PULL    = 2'd2,
    MODE_START   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_PIXEL = 3'd0,
    ST_NEED  = 3'd1,
    ST_END   = 3'd2,
    ST_OK    = 3'd3,
    ST_FULL  = 3'd4,
    ST_BAD   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PULL,
    S_CODE,
    S_WALK,
    S_WALK_RD,
    S_STK,
    S_PALIDX,
    S_PAL
  } state_t;

  typedef enum logic [1:0] {
    BB_NONE,
    BB_CLEAR,
    BB_PUSH,
    BB_TAKE
  } bb_cmd_t;

  typedef struct packed {
    bb_cmd_t         cmd;
    logic [7:0]      data;
    logic [CW_W-1:0] width;
  } bb_ctl_t;

  // clamp of the minimum code size into the legal range
  function automatic logic [3:0] eff_size(input logic [3:0] mcs);
    logic [3:0] r;
    r = mcs;
    if (mcs < MCS_LOW) r = MCS_LOW;
    if (mcs > MCS_HIGH) r = MCS_HIGH;
    return r;
  endfunction

endpackage

### design/glzw_ram.sv
module glzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/glzw_bitbuf.sv
module glzw_bitbuf import glzw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  bb_ctl_t                  ctl,
  output logic [CNT_W-1:0]         count,
  output logic [MAX_CODE_BITS-1:0] code
);

  logic [BUF_BITS-1:0] bits;
  logic [BUF_BITS-1:0] bits_next;
  logic [CNT_W-1:0]    count_next;
  logic [BUF_BITS-1:0] mask;
  logic [BUF_BITS-1:0] masked;

  // low code_width bits, least significant bit first
  assign mask   = (BUF_BITS'(1) << ctl.width) - BUF_BITS'(1);
  assign masked = bits & mask;
  assign code   = masked[MAX_CODE_BITS-1:0];

  always_comb begin
    bits_next  = bits;
    count_next = count;
    case (ctl.cmd)
      BB_CLEAR: begin
        bits_next  = '0;
        count_next = '0;
      end
      BB_PUSH: begin
        bits_next  = bits | (BUF_BITS'(ctl.data) << count);
        count_next = count + CNT_W'(8);
      end
      BB_TAKE: begin
        bits_next  = bits >> ctl.width;
        count_next = count - CNT_W'(ctl.width);
      end
      default: begin
        bits_next  = bits;
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits  <= '0;
      count <= '0;
    end else begin
      bits  <= bits_next;
      count <= count_next;
    end
  end

endmodule

### design/gif_lzw_pixel_decoder.sv
// gif lzw pixel decoder: variable-width lzw (lsb-first codes, up to 12 bits)
// command channel: an item is taken at a clock edge with start high and busy
// low. mode selects palette write, push of one code byte, pull of one pixel
// or start of a new image. every item answers with exactly one result, shown
// for one cycle with done high; status says what happened and the pixel
// fields carry index and palette colour when status is pixel, else zero.
// palette write, push and start image answer in the cycle after acceptance
// and leave busy low, so a new item can be taken every cycle. a pull popping
// a pending symbol passes s_pull, s_stk, s_pal; one reading a new code passes
// s_pull, s_code, s_walk and s_walk_rd per symbol of the chain walk through
// the prefix/suffix tables (registered reads), then s_palidx or s_stk, and
// s_pal; a literal after a clear skips the walk, a clear code read on the
// way returns to s_pull. busy is high meanwhile. min_code_size is written by
// cfg_write/cfg_data, by the user only while the block is idle; the block
// does not enforce it. a synchronous rst empties the bit buffer and the stack
// and restarts the table state; palette and table contents are undefined
// until written. the receiver cannot stall: every result must be taken
// when done is high.
module gif_lzw_pixel_decoder import glzw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] mode,
  input  logic [7:0] palette_slot,
  input  logic [7:0] entry_red,
  input  logic [7:0] entry_green,
  input  logic [7:0] entry_blue,
  input  logic [7:0] stream_byte,
  input  logic       cfg_write,
  input  logic [3:0] cfg_data,
  output logic       done,
  output logic [2:0] status,
  output logic [7:0] pixel_index,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  state_t state, state_next;

  logic [3:0]               min_code_size;
  logic [DEPTH_W-1:0]       stack_depth, stack_depth_next;
  logic [NFC_W-1:0]         next_free, next_free_next;
  logic [CW_W-1:0]          code_width, code_width_next;
  logic [MAX_CODE_BITS-1:0] prev_code, prev_code_next;
  logic [7:0]               first_sym, first_sym_next;
  logic                     after_clear, after_clear_next;
  logic                     image_done, image_done_next;
  logic [MAX_CODE_BITS-1:0] code, code_next;
  logic [MAX_CODE_BITS-1:0] walk, walk_next;
  logic [7:0]               pix_idx, pix_idx_next;

  logic       done_next;
  status_t    status_next;
  logic [7:0] pixel_index_next, out_red_next, out_green_next, out_blue_next;

  logic [3:0]       eff;
  logic [NFC_W-1:0] clr;
  logic [NFC_W-1:0] code_ext;
  logic [NFC_W-1:0] walk_ext;
  logic [NFC_W-1:0] next_free_inc;
  logic             stack_room;

  bb_ctl_t                  bb_ctl;
  logic [CNT_W-1:0]         bb_count;
  logic [MAX_CODE_BITS-1:0] bb_code;

  logic              pal_we;
  logic [PAL_AW-1:0] pal_waddr, pal_raddr;
  logic [23:0]       pal_wdata, pal_rdata;

  logic              stk_we;
  logic [TAB_AW-1:0] stk_waddr, stk_raddr;
  logic [7:0]        stk_wdata, stk_rdata;

  logic                     tab_we;
  logic [TAB_AW-1:0]        tab_waddr, tab_raddr;
  logic [MAX_CODE_BITS-1:0] pre_wdata, pre_rdata;
  logic [7:0]               suf_wdata, suf_rdata;

  glzw_bitbuf u_bitbuf (
    .clk   (clk),
    .rst   (rst),
    .ctl   (bb_ctl),
    .count (bb_count),
    .code  (bb_code)
  );

  glzw_ram #(.WIDTH(24), .DEPTH(PALETTE_ENTRIES)) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  glzw_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  glzw_ram #(.WIDTH(MAX_CODE_BITS), .DEPTH(TABLE_ENTRIES)) u_prefix (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (pre_wdata),
    .raddr (tab_raddr),
    .rdata (pre_rdata)
  );

  glzw_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_suffix (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (suf_wdata),
    .raddr (tab_raddr),
    .rdata (suf_rdata)
  );

  assign busy          = (state != S_IDLE);
  assign eff           = eff_size(min_code_size);
  assign clr           = NFC_W'(1) << eff;
  assign code_ext      = NFC_W'(code);
  assign walk_ext      = NFC_W'(walk);
  assign next_free_inc = next_free + NFC_W'(1);
  assign stack_room    = (stack_depth < DEPTH_W'(TABLE_ENTRIES));

  always_comb begin
    state_next       = state;
    stack_depth_next = stack_depth;
    next_free_next   = next_free;
    code_width_next  = code_width;
    prev_code_next   = prev_code;
    first_sym_next   = first_sym;
    after_clear_next = after_clear;
    image_done_next  = image_done;
    code_next        = code;
    walk_next        = walk;
    pix_idx_next     = pix_idx;

    done_next        = 1'b0;
    status_next      = status_t'(status);
    pixel_index_next = '0;
    out_red_next     = '0;
    out_green_next   = '0;
    out_blue_next    = '0;

    bb_ctl       = '{cmd: BB_NONE, data: stream_byte, width: code_width};
    pal_we       = 1'b0;
    pal_waddr    = palette_slot[PAL_AW-1:0];
    pal_wdata    = {entry_red, entry_green, entry_blue};
    pal_raddr    = pix_idx[PAL_AW-1:0];
    stk_we       = 1'b0;
    stk_waddr    = stack_depth[TAB_AW-1:0];
    stk_wdata    = first_sym;
    stk_raddr    = stack_depth[TAB_AW-1:0] - TAB_AW'(1);
    tab_we       = 1'b0;
    tab_waddr    = next_free[TAB_AW-1:0];
    tab_raddr    = walk[TAB_AW-1:0];
    pre_wdata    = prev_code;
    suf_wdata    = walk[7:0];

    case (state)
      S_IDLE: begin
        if (start) begin
          case (mode_t'(mode))
            MODE_PALETTE: begin
              pal_we      = ({1'b0, palette_slot} < 9'(PALETTE_ENTRIES));
              done_next   = 1'b1;
              status_next = ST_OK;
            end
            MODE_PUSH: begin
              done_next = 1'b1;
              if (6'(bb_count) + 6'd8 > 6'(BUF_BITS)) begin
                status_next = ST_FULL;
              end else begin
                bb_ctl.cmd  = BB_PUSH;
                status_next = ST_OK;
              end
            end
            MODE_PULL: begin
              state_next = S_PULL;
            end
            default: begin
              bb_ctl.cmd       = BB_CLEAR;
              stack_depth_next = '0;
              prev_code_next   = '0;
              first_sym_next   = '0;
              image_done_next  = 1'b0;
              next_free_next   = clr + NFC_W'(2);
              code_width_next  = eff + CW_W'(1);
              after_clear_next = 1'b1;
              done_next        = 1'b1;
              status_next      = ST_OK;
            end
          endcase
        end
      end

      S_PULL: begin
        if (image_done) begin
          done_next   = 1'b1;
          status_next = ST_END;
          state_next  = S_IDLE;
        end else if (stack_depth != '0) begin
          stack_depth_next = stack_depth - DEPTH_W'(1);
          state_next       = S_STK;
        end else if (bb_count < CNT_W'(code_width)) begin
          done_next   = 1'b1;
          status_next = ST_NEED;
          state_next  = S_IDLE;
        end else begin
          bb_ctl.cmd = BB_TAKE;
          code_next  = bb_code;
          state_next = S_CODE;
        end
      end

      S_CODE: begin
        if (code_ext == clr) begin
          next_free_next   = clr + NFC_W'(2);
          code_width_next  = eff + CW_W'(1);
          after_clear_next = 1'b1;
          state_next       = S_PULL;
        end else if (code_ext == clr + NFC_W'(1)) begin
          image_done_next = 1'b1;
          done_next       = 1'b1;
          status_next     = ST_END;
          state_next      = S_IDLE;
        end else if (after_clear) begin
          if (code_ext > clr) begin
            done_next   = 1'b1;
            status_next = ST_BAD;
            state_next  = S_IDLE;
          end else begin
            // literal: pushed and popped at once, straight to the palette
            after_clear_next = 1'b0;
            prev_code_next   = code;
            first_sym_next   = code[7:0];
            pix_idx_next     = code[7:0];
            state_next       = S_PALIDX;
          end
        end else if (code_ext > next_free ||
                     (code_ext == next_free && next_free >= NFC_W'(TABLE_ENTRIES))) begin
          done_next   = 1'b1;
          status_next = ST_BAD;
          state_next  = S_IDLE;
        end else if (code_ext == next_free) begin
          // code not yet in the table: string of previous code plus its first symbol
          if (stack_room) begin
            stk_we           = 1'b1;
            stk_wdata        = first_sym;
            stack_depth_next = stack_depth + DEPTH_W'(1);
          end
          walk_next  = prev_code;
          state_next = S_WALK;
        end else begin
          walk_next  = code;
          state_next = S_WALK;
        end
      end

      S_WALK: begin
        if (walk_ext >= clr + NFC_W'(2) && walk_ext < NFC_W'(TABLE_ENTRIES) &&
            stack_room) begin
          state_next = S_WALK_RD;
        end else begin
          first_sym_next = walk[7:0];
          prev_code_next = code;
          if (next_free < NFC_W'(TABLE_ENTRIES)) begin
            tab_we         = 1'b1;
            next_free_next = next_free_inc;
            if (next_free_inc == (NFC_W'(1) << code_width) &&
                code_width < CW_W'(MAX_CODE_BITS)) begin
              code_width_next = code_width + CW_W'(1);
            end
          end
          if (stack_room) begin
            // root symbol would be pushed and popped right away
            pix_idx_next = walk[7:0];
            state_next   = S_PALIDX;
          end else begin
            stack_depth_next = stack_depth - DEPTH_W'(1);
            state_next       = S_STK;
          end
        end
      end

      S_WALK_RD: begin
        stk_we           = 1'b1;
        stk_wdata        = suf_rdata;
        stack_depth_next = stack_depth + DEPTH_W'(1);
        walk_next        = pre_rdata;
        state_next       = S_WALK;
      end

      S_STK: begin
        pix_idx_next = stk_rdata;
        pal_raddr    = stk_rdata[PAL_AW-1:0];
        state_next   = S_PAL;
      end

      S_PALIDX: begin
        pal_raddr  = pix_idx[PAL_AW-1:0];
        state_next = S_PAL;
      end

      S_PAL: begin
        done_next        = 1'b1;
        status_next      = ST_PIXEL;
        pixel_index_next = pix_idx;
        if ({1'b0, pix_idx} < 9'(PALETTE_ENTRIES)) begin
          out_red_next   = pal_rdata[23:16];
          out_green_next = pal_rdata[15:8];
          out_blue_next  = pal_rdata[7:0];
        end
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      min_code_size <= MCS_RESET;
      stack_depth   <= '0;
      next_free     <= (NFC_W'(1) << eff_size(MCS_RESET)) + NFC_W'(2);
      code_width    <= eff_size(MCS_RESET) + CW_W'(1);
      prev_code     <= '0;
      first_sym     <= '0;
      after_clear   <= 1'b1;
      image_done    <= 1'b0;
      done          <= 1'b0;
      status        <= ST_OK;
    end else begin
      state       <= state_next;
      if (cfg_write) begin
        min_code_size <= cfg_data;
      end
      stack_depth <= stack_depth_next;
      next_free   <= next_free_next;
      code_width  <= code_width_next;
      prev_code   <= prev_code_next;
      first_sym   <= first_sym_next;
      after_clear <= after_clear_next;
      image_done  <= image_done_next;
      done        <= done_next;
      status      <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    code        <= code_next;
    walk        <= walk_next;
    pix_idx     <= pix_idx_next;
    pixel_index <= pixel_index_next;
    out_red     <= out_red_next;
    out_green   <= out_green_next;
    out_blue    <= out_blue_next;
  end

endmodule
